### sv/fim_pkg.sv
// fim_pkg: shared widths, register codes and word types of the frame index remap block
// no dependencies; every other file imports this package
`timescale 1ns / 1ps

package fim_pkg;

    localparam int FRAME_BITS   = 21;
    localparam int SCALE_BITS   = 15;
    localparam int PASS_BITS    = 8;
    localparam int FLAG_BITS    = 4;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DW       = FRAME_BITS;
    // clamped start/end are non-negative
    localparam int SW  = FRAME_BITS - 1;
    // signed frame times scale
    localparam int PW  = FRAME_BITS + SCALE_BITS + 1;
    // scaled frame, at least one
    localparam int CW  = FRAME_BITS + 6;
    // dividend of the wrap division
    localparam int TW  = FRAME_BITS + 7;
    // divisor and remainder
    localparam int DW  = FRAME_BITS;
    // signed result before saturation
    localparam int RSW = TW + 2;

    localparam int FLG_LOOP     = 0;
    localparam int FLG_INV_NAME = 1;
    localparam int FLG_INV_PASS = 2;
    localparam int FLG_NAME_ON  = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODE    = 3'd0,
        REG_FLAGS   = 3'd1,
        REG_START   = 3'd2,
        REG_END     = 3'd3,
        REG_OFFSET  = 3'd4,
        REG_SCALE   = 3'd5,
        REG_PASS    = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_FIXED    = 2'd0,
        MODE_NORMAL   = 2'd1,
        MODE_REVERSE  = 2'd2,
        MODE_PINGPONG = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [FRAME_BITS-1:0] frame;
        logic [PASS_BITS-1:0]         layer_pass_index;
        logic                         layer_name_match;
    } t_in_word;

    typedef struct packed {
        logic signed [FRAME_BITS-1:0] mapped_frame;
        logic                         passed_through;
    } t_out_word;

    // register set after clamping and offset folding
    typedef struct packed {
        t_mode                  mode;
        logic [FLAG_BITS-1:0]   flags;
        logic [SW-1:0]          start;
        logic [SW-1:0]          stop;
        logic [FRAME_BITS-1:0]  off;
        logic [SCALE_BITS-1:0]  scale;
        logic [PASS_BITS-1:0]   pass;
        logic                   empty;
    } t_cfg;

    // per-item data that rides alongside the divider
    typedef struct packed {
        logic signed [FRAME_BITS-1:0] frame;
        logic                         thru;
        logic [CW-1:0]                c;
        logic [TW-1:0]                t;
    } t_side;

endpackage

### sv/fim_prep.sv
// fim_prep: filter decision, scale multiply and wrap operand setup, three register stages
// depends on fim_pkg
`timescale 1ns / 1ps

module fim_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  fim_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  fim_pkg::t_in_word i_word,
    output logic              o_valid,
    output fim_pkg::t_side    o_side,
    output logic [fim_pkg::DW-1:0] o_div
);
    import fim_pkg::*;

    logic                         r_a_v, r_b_v, r_c_v;
    logic signed [FRAME_BITS-1:0] r_a_frame, r_b_frame;
    logic                         r_a_thr, r_b_thr;
    logic signed [PW-1:0]         r_b_prod;
    t_side                        r_c_side;
    logic [DW-1:0]                r_c_div;

    logic                         n_thr;
    logic                         name_fail, pass_fail, pass_eq;
    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         rnd;
    logic signed [PW-1:0]         q8;
    logic [CW-1:0]                n_c;
    logic [TW-1:0]                n_t;
    logic [SW-1:0]                len;
    logic [DW-1:0]                n_div;

    always_comb begin
        name_fail = i_cfg.flags[FLG_INV_NAME] ? i_word.layer_name_match
                                              : !i_word.layer_name_match;
        pass_eq   = (i_word.layer_pass_index == i_cfg.pass);
        pass_fail = i_cfg.flags[FLG_INV_PASS] ? pass_eq : !pass_eq;
        n_thr     = i_cfg.empty
                  || (i_cfg.flags[FLG_NAME_ON] && name_fail)
                  || ((i_cfg.pass != '0) && pass_fail);
    end

    assign prod = PW'($signed(r_a_frame)) * $signed({{(PW-SCALE_BITS){1'b0}}, i_cfg.scale});

    // truncate toward zero, then floor at one
    always_comb begin
        rnd = r_b_prod + (r_b_prod[PW-1] ? PW'(255) : PW'(0));
        q8  = rnd >>> 8;
        n_c = (q8 < PW'(1)) ? CW'(1) : q8[CW-1:0];
        n_t = TW'(n_c) + TW'(i_cfg.off) - TW'(1);
        len = i_cfg.stop - i_cfg.start;
        if (i_cfg.empty) begin
            n_div = DW'(1);
        end else if (i_cfg.mode == MODE_PINGPONG) begin
            n_div = DW'(len);
        end else begin
            n_div = DW'(len) + DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_frame      <= i_word.frame;
            r_a_thr        <= n_thr;
            r_b_frame      <= r_a_frame;
            r_b_thr        <= r_a_thr;
            r_b_prod       <= prod;
            r_c_side.frame <= r_b_frame;
            r_c_side.thru  <= r_b_thr;
            r_c_side.c     <= n_c;
            r_c_side.t     <= n_t;
            r_c_div        <= n_div;
        end
    end

    assign o_valid = r_c_v;
    assign o_side  = r_c_side;
    assign o_div   = r_c_div;

endmodule

### sv/fim_div.sv
// fim_div: pipelined restoring divider, one quotient bit per register stage
// depends on fim_pkg; gives remainder and quotient parity of side.t over the divisor
`timescale 1ns / 1ps

module fim_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  fim_pkg::t_side          i_side,
    input  logic [fim_pkg::DW-1:0]  i_div,
    output logic                    o_valid,
    output fim_pkg::t_side          o_side,
    output logic [fim_pkg::DW-1:0]  o_rem,
    output logic                    o_qlsb
);
    import fim_pkg::*;

    logic          r_v    [TW];
    t_side         r_side [TW];
    logic [DW-1:0] r_d    [TW];
    logic [DW-1:0] r_rem  [TW];
    logic [TW-1:0] r_num  [TW];
    logic          r_qb   [TW];

    for (genvar k = 0; k < TW; k++) begin : g_stage
        logic          p_v;
        t_side         p_side;
        logic [DW-1:0] p_d, p_rem;
        logic [TW-1:0] p_num;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_side = i_side;
            assign p_d    = i_div;
            assign p_rem  = '0;
            assign p_num  = i_side.t;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_side = r_side[k-1];
            assign p_d    = r_d[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_num  = r_num[k-1];
        end

        assign trial = {p_rem, p_num[TW-1]};
        assign ge    = (trial >= {1'b0, p_d});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= p_side;
                r_d[k]    <= p_d;
                r_rem[k]  <= ge ? DW'(trial - {1'b0, p_d}) : DW'(trial);
                r_num[k]  <= {p_num[TW-2:0], 1'b0};
                r_qb[k]   <= ge;
            end
        end
    end

    assign o_valid = r_v[TW-1];
    assign o_side  = r_side[TW-1];
    assign o_rem   = r_rem[TW-1];
    assign o_qlsb  = r_qb[TW-1];

endmodule

### sv/fim_map.sv
// fim_map: playback mode selection, saturation and the output word register
// depends on fim_pkg
`timescale 1ns / 1ps

module fim_map (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  fim_pkg::t_cfg           i_cfg,
    input  logic                    i_valid,
    input  fim_pkg::t_side          i_side,
    input  logic [fim_pkg::DW-1:0]  i_rem,
    input  logic                    i_qlsb,
    output logic                    o_valid,
    output fim_pkg::t_out_word      o_word
);
    import fim_pkg::*;

    logic              r_valid;
    t_out_word         r_word;

    logic signed [RSW-1:0] s, e, t, r, o, c, x, et, len, res;
    logic signed [RSW-1:0] sat_hi, sat_lo;
    logic                  loop;
    t_out_word             n_word;

    always_comb begin
        s      = $signed({{(RSW-SW){1'b0}}, i_cfg.start});
        e      = $signed({{(RSW-SW){1'b0}}, i_cfg.stop});
        t      = $signed({{(RSW-TW){1'b0}}, i_side.t});
        r      = $signed({{(RSW-DW){1'b0}}, i_rem});
        o      = $signed({{(RSW-FRAME_BITS){1'b0}}, i_cfg.off});
        c      = $signed({{(RSW-CW){1'b0}}, i_side.c});
        loop   = i_cfg.flags[FLG_LOOP];
        x      = t + s;
        et     = e - t;
        len    = e - s;
        sat_hi = $signed({{(RSW-FRAME_BITS+1){1'b0}}, {(FRAME_BITS-1){1'b1}}});
        sat_lo = -sat_hi - RSW'(1);
        case (i_cfg.mode)
            MODE_FIXED: begin
                res = o;
            end
            MODE_NORMAL: begin
                if (loop) res = r + s;
                else      res = (x < e) ? x : e;
            end
            MODE_REVERSE: begin
                if (loop) res = e - r;
                else      res = (et > s + RSW'(1)) ? et : s;
            end
            MODE_PINGPONG: begin
                res = i_qlsb ? (e - r) : (s + r);
                if (!loop && (c > (len <<< 1))) res = s + o;
            end
            default: begin
                res = o;
            end
        endcase
        if (i_side.thru) begin
            n_word.mapped_frame   = i_side.frame;
            n_word.passed_through = 1'b1;
        end else begin
            if (res > sat_hi)      n_word.mapped_frame = sat_hi[FRAME_BITS-1:0];
            else if (res < sat_lo) n_word.mapped_frame = sat_lo[FRAME_BITS-1:0];
            else                   n_word.mapped_frame = res[FRAME_BITS-1:0];
            n_word.passed_through = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### sv/frame_index_remap.sv
// frame_index_remap: top level, configuration registers and pipeline stall control
// depends on fim_pkg, fim_prep, fim_div, fim_map
`timescale 1ns / 1ps

// frame index remap for looped, reversed and ping-pong playback. each input word
// (frame, layer pass index, name-match bit) gives exactly one output word in order.
// the block takes one word per clock unless the sink stalls the output. it has
// three setup stages (filters, the scale multiply, truncation and wrap operands),
// one divider stage per bit of the wrap dividend (FRAME_BITS + 7 of them) and the
// output register, all enabled together. the pipeline runs as one unit:
// it freezes only while the output register holds a word that the sink stalls,
// so a new word is taken whenever the output slot is free or being emptied.
// configuration registers are written through the cfg channel, which is always
// ready; write them only while no word is in flight. a write to an index past
// the register list is accepted and ignored.
module frame_index_remap (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  fim_pkg::t_in_word                 i_in_word,
    // output words
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output fim_pkg::t_out_word                o_out_word,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fim_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [fim_pkg::CFG_DW-1:0]        i_cfg_data
);
    import fim_pkg::*;

    // raw registers as written
    t_mode                        r_mode;
    logic [FLAG_BITS-1:0]         r_flags;
    logic signed [FRAME_BITS-1:0] r_start;
    logic signed [FRAME_BITS-1:0] r_end;
    logic signed [FRAME_BITS-1:0] r_offset;
    logic [SCALE_BITS-1:0]        r_scale;
    logic [PASS_BITS-1:0]         r_pass;

    t_cfg                         cfg;
    logic [SW-1:0]                s_clamp, e_clamp;
    logic signed [FRAME_BITS+1:0] fold;
    logic                         en;

    logic                         prep_valid, div_valid, div_qlsb;
    t_side                        prep_side, div_side;
    logic [DW-1:0]                prep_div, div_rem;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_flags  <= '0;
            r_start  <= FRAME_BITS'(1);
            r_end    <= FRAME_BITS'(250);
            r_offset <= '0;
            r_scale  <= SCALE_BITS'(256);
            r_pass   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                REG_FLAGS:  r_flags  <= i_cfg_data[FLAG_BITS-1:0];
                REG_START:  r_start  <= i_cfg_data[FRAME_BITS-1:0];
                REG_END:    r_end    <= i_cfg_data[FRAME_BITS-1:0];
                REG_OFFSET: r_offset <= i_cfg_data[FRAME_BITS-1:0];
                REG_SCALE:  r_scale  <= i_cfg_data[SCALE_BITS-1:0];
                REG_PASS:   r_pass   <= i_cfg_data[PASS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp the window to non-negative frames and fold a negative offset in as
    // |end-start+offset+1|; user keeps it static with words in flight, unenforced
    always_comb begin
        s_clamp = r_start[FRAME_BITS-1] ? '0 : r_start[SW-1:0];
        e_clamp = r_end[FRAME_BITS-1]   ? '0 : r_end[SW-1:0];
        fold    = $signed({2'b00, e_clamp}) - $signed({2'b00, s_clamp})
                + $signed({{2{r_offset[FRAME_BITS-1]}}, r_offset})
                + (FRAME_BITS+2)'(1);
        cfg.mode  = r_mode;
        cfg.flags = r_flags;
        cfg.start = s_clamp;
        cfg.stop  = e_clamp;
        cfg.scale = r_scale;
        cfg.pass  = r_pass;
        cfg.empty = (e_clamp <= s_clamp);
        if (!r_offset[FRAME_BITS-1]) begin
            cfg.off = r_offset;
        end else if (fold < 0) begin
            cfg.off = FRAME_BITS'(-fold);
        end else begin
            cfg.off = fold[FRAME_BITS-1:0];
        end
    end

    // whole pipe advances unless the output word is held by the sink
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    fim_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_valid (prep_valid),
        .o_side  (prep_side),
        .o_div   (prep_div)
    );

    fim_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_valid),
        .i_side  (prep_side),
        .i_div   (prep_div),
        .o_valid (div_valid),
        .o_side  (div_side),
        .o_rem   (div_rem),
        .o_qlsb  (div_qlsb)
    );

    fim_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_valid (div_valid),
        .i_side  (div_side),
        .i_rem   (div_rem),
        .i_qlsb  (div_qlsb),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

    // no output word straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output word valid right after reset");

    // scale register takes the written data
    a_scale_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == REG_SCALE)
        |=> r_scale == $past(i_cfg_data[SCALE_BITS-1:0]))
        else $error("scale register write lost");

    // mode changes only through a configuration write
    a_mode_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_valid |=> $stable(r_mode))
        else $error("mode register changed without a write");

    // a word at the output that the sink stalls keeps the pipe frozen
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(div_side) && $stable(div_valid))
        else $error("pipeline moved while output stalled");

endmodule

### tb/fim_checker.sv
// fim_checker: watches the word and cfg channels of frame_index_remap, predicts every output word
// depends on fim_pkg; instantiated beside the block by frame_index_remap_tb
`timescale 1ns / 1ps

module fim_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  fim_pkg::t_in_word                 i_in_word,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  fim_pkg::t_out_word                i_out_word,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [fim_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [fim_pkg::CFG_DW-1:0]        i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import fim_pkg::*;

    t_mode                        mode_q;
    logic [FLAG_BITS-1:0]         flags_q;
    logic signed [FRAME_BITS-1:0] start_q;
    logic signed [FRAME_BITS-1:0] end_q;
    logic signed [FRAME_BITS-1:0] offset_q;
    logic [SCALE_BITS-1:0]        scale_q;
    logic [PASS_BITS-1:0]         pass_q;

    t_out_word expected_frames[$];

    function automatic longint clamp_frame(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (FRAME_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_out_word remap_frame(t_in_word w);
        t_out_word r;
        longint    fr, s, e, off, c, len, t, res;
        bit        thru, looping;
        fr      = longint'(w.frame);
        s       = longint'(start_q);
        e       = longint'(end_q);
        off     = longint'(offset_q);
        looping = flags_q[FLG_LOOP];
        res     = 0;
        if (s < 0) s = 0;
        if (e < 0) e = 0;
        // negative offset folds into the range
        if (off < 0) begin
            off = e - s + off + 1;
            if (off < 0) off = -off;
        end
        thru = (e <= s);
        if (!thru && flags_q[FLG_NAME_ON]
            && (flags_q[FLG_INV_NAME] ? w.layer_name_match : !w.layer_name_match))
            thru = 1;
        if (!thru && pass_q != 0
            && (flags_q[FLG_INV_PASS] ? (w.layer_pass_index == pass_q)
                                      : (w.layer_pass_index != pass_q)))
            thru = 1;
        if (thru) begin
            r.mapped_frame   = w.frame;
            r.passed_through = 1'b1;
            return r;
        end
        c = (fr * longint'({1'b0, scale_q})) / 256;
        if (c < 1) c = 1;
        t = c + off - 1;
        case (mode_q)
            MODE_FIXED: res = off;
            MODE_NORMAL: begin
                if (!looping) res = (c + s + off - 1 < e) ? c + s + off - 1 : e;
                else res = t % (e - s + 1) + s;
            end
            MODE_REVERSE: begin
                if (!looping) res = (e - c - off > s) ? e - c - off + 1 : s;
                else res = e - t % (e - s + 1);
            end
            default: begin
                len = e - s;
                if ((t / len) % 2 != 0) res = e - t % len;
                else res = s + t % len;
                // ping-pong without looping parks after two sweeps
                if (!looping && c > len * 2) res = s + off;
            end
        endcase
        res              = clamp_frame(res);
        r.mapped_frame   = res[FRAME_BITS-1:0];
        r.passed_through = 1'b0;
        return r;
    endfunction

    assign o_pending = expected_frames.size();

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            mode_q   <= MODE_NORMAL;
            flags_q  <= '0;
            start_q  <= 1;
            end_q    <= 250;
            offset_q <= 0;
            scale_q  <= 256;
            pass_q   <= '0;
            expected_frames.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_frames.push_back(remap_frame(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected word, actual %0d/%0b", $time,
                             i_out_word.mapped_frame, i_out_word.passed_through);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = expected_frames.pop_front();
                    if (exp_w.mapped_frame !== i_out_word.mapped_frame) begin
                        $display("%0t: mapped_frame expected %0d actual %0d", $time,
                                 exp_w.mapped_frame, i_out_word.mapped_frame);
                        o_fail_count <= o_fail_count + 1;
                    end else if (exp_w.passed_through !== i_out_word.passed_through) begin
                        $display("%0t: passed_through expected %0b actual %0b", $time,
                                 exp_w.passed_through, i_out_word.passed_through);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    REG_MODE:   mode_q   <= t_mode'(i_cfg_data[1:0]);
                    REG_FLAGS:  flags_q  <= i_cfg_data[FLAG_BITS-1:0];
                    REG_START:  start_q  <= i_cfg_data;
                    REG_END:    end_q    <= i_cfg_data;
                    REG_OFFSET: offset_q <= i_cfg_data;
                    REG_SCALE:  scale_q  <= i_cfg_data[SCALE_BITS-1:0];
                    REG_PASS:   pass_q   <= i_cfg_data[PASS_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/frame_index_remap_tb.sv
// frame_index_remap_tb: stimulus, sink stalls, watchdog and verdict for frame_index_remap
// depends on fim_pkg, frame_index_remap and fim_checker
`timescale 1ns / 1ps

module frame_index_remap_tb;
    import fim_pkg::*;

    // drain margin that covers the setup, divider and output stages of the pipeline
    localparam int DRAIN_CYCLES = FRAME_BITS + 20;
    localparam int WATCHDOG_MAX = 3000;
    localparam int HOLD_AT      = 900;
    localparam int HOLD_LEN     = 400;
    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 125;
    localparam logic [FRAME_BITS-1:0] FRAME_MIN = {1'b1, {(FRAME_BITS-1){1'b0}}};
    localparam logic [FRAME_BITS-1:0] FRAME_MAX = {1'b0, {(FRAME_BITS-1){1'b1}}};

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_word   in_word;
    logic       out_valid;
    logic       out_stall;
    t_out_word  out_word;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DW-1:0]       cfg_data;
    int         fail_count;
    int         pending;
    int         cycle_count;
    int         idle_cycles;
    bit         no_gaps;

    // one full register set, written as a block between phases
    typedef struct {
        t_mode                 mode;
        logic [FLAG_BITS-1:0]  flags;
        logic [FRAME_BITS-1:0] start;
        logic [FRAME_BITS-1:0] stop;
        logic [FRAME_BITS-1:0] offset;
        logic [SCALE_BITS-1:0] scale;
        logic [PASS_BITS-1:0]  pass;
    } t_remap_setup;

    frame_index_remap u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fim_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // sink side: random stalls, plus one long hold-off so the pipeline backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall   <= 1'b0;
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= HOLD_AT && cycle_count < HOLD_AT + HOLD_LEN)
                out_stall <= 1'b1;
            else if (no_gaps)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_valid && !in_stall) || (out_valid && !out_stall)
                     || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(t_in_word w);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // registers change only with nothing in flight
    task automatic apply_setup(t_remap_setup cs);
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_MODE,   CFG_DW'(cs.mode));
        write_reg(REG_FLAGS,  CFG_DW'(cs.flags));
        write_reg(REG_START,  cs.start);
        write_reg(REG_END,    cs.stop);
        write_reg(REG_OFFSET, cs.offset);
        write_reg(REG_SCALE,  CFG_DW'(cs.scale));
        write_reg(REG_PASS,   CFG_DW'(cs.pass));
    endtask

    // random register set, mostly a sane window so the mapping path is exercised
    function automatic t_remap_setup random_setup();
        t_remap_setup cs;
        int r;
        cs.mode  = t_mode'($urandom_range(0, 3));
        cs.flags = FLAG_BITS'($urandom_range(0, 15));
        r = $urandom_range(0, 9);
        cs.start = (r == 0) ? FRAME_MIN : (r == 1) ? FRAME_MAX
                 : FRAME_BITS'($urandom_range(0, 100));
        r = $urandom_range(0, 9);
        cs.stop  = (r == 0) ? FRAME_MAX : (r == 1) ? FRAME_MIN
                 : (r == 2) ? FRAME_BITS'($urandom)
                 : FRAME_BITS'($signed(cs.start) < 0 ? 0 : cs.start) +
                   FRAME_BITS'($urandom_range(1, 500));
        r = $urandom_range(0, 9);
        cs.offset = (r == 0) ? FRAME_MIN : (r == 1) ? FRAME_MAX
                  : FRAME_BITS'($urandom_range(0, 100) - 50);
        r = $urandom_range(0, 9);
        cs.scale = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? SCALE_BITS'(25600)
                 : SCALE_BITS'($urandom_range(64, 1024));
        cs.pass  = ($urandom_range(0, 2) == 0) ? PASS_BITS'($urandom) : '0;
        return cs;
    endfunction

    function automatic t_in_word random_word(t_remap_setup cs);
        t_in_word w;
        w.frame = ($urandom_range(0, 4) == 0) ? FRAME_BITS'($urandom)
                : FRAME_BITS'($urandom_range(0, 700) - 50);
        w.layer_pass_index = ($urandom_range(0, 1) == 0) ? cs.pass : PASS_BITS'($urandom);
        w.layer_name_match = 1'($urandom_range(0, 1));
        return w;
    endfunction

    initial begin
        t_remap_setup cs;
        t_in_word     w;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        no_gaps   = 1'b0;
        i_rst_n   <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        @(posedge i_clk);

        // reset settings: field extremes, window edges
        cs = '{MODE_NORMAL, 4'd0, 21'd1, 21'd250, 21'd0, 15'd256, 8'd0};
        send_word('{FRAME_MIN, 8'd0, 1'b0});
        send_word('{FRAME_MAX, 8'hFF, 1'b1});
        send_word('{21'sd0, 8'd0, 1'b0});
        send_word('{21'sd1, 8'd1, 1'b1});
        send_word('{21'sd250, 8'd0, 1'b0});
        send_word('{21'sd251, 8'd0, 1'b0});
        send_word('{-21'sd1, 8'd0, 1'b0});

        // inverted window passes the frame through
        apply_setup('{MODE_NORMAL, 4'd0, 21'd300, 21'd10, 21'd0, 15'd256, 8'd0});
        send_word('{21'sd77, 8'd3, 1'b0});
        // name filter plain then inverted, pass filter plain then inverted
        apply_setup('{MODE_REVERSE, 4'b1001, 21'd0, 21'd40, 21'd5, 15'd256, 8'd7});
        send_word('{21'sd12, 8'd7, 1'b1});
        send_word('{21'sd12, 8'd7, 1'b0});
        send_word('{21'sd12, 8'd8, 1'b1});
        apply_setup('{MODE_PINGPONG, 4'b1110, 21'd2, 21'd12, -21'sd3, 15'd384, 8'd7});
        send_word('{21'sd15, 8'd7, 1'b0});
        send_word('{21'sd15, 8'd9, 1'b0});
        send_word('{21'sd15, 8'd9, 1'b1});
        // ping-pong without looping, past two sweeps
        apply_setup('{MODE_PINGPONG, 4'd0, 21'd5, 21'd15, 21'd2, 15'd256, 8'd0});
        send_word('{21'sd8, 8'd0, 1'b0});
        send_word('{21'sd40, 8'd0, 1'b0});
        // fixed frame with a negative offset folded in, zero scale
        apply_setup('{MODE_FIXED, 4'd1, -21'sd20, 21'd30, -21'sd50, 15'd0, 8'd0});
        send_word('{21'sd100, 8'd0, 1'b0});
        // looping normal and reverse, scale above nominal range
        apply_setup('{MODE_NORMAL, 4'd1, 21'd10, 21'd20, 21'd0, 15'h7FFF, 8'd0});
        send_word('{21'sd333, 8'd0, 1'b0});
        send_word('{FRAME_MIN, 8'd0, 1'b0});
        apply_setup('{MODE_REVERSE, 4'd1, 21'd0, FRAME_MAX, FRAME_MAX, 15'd25600, 8'd0});
        send_word('{FRAME_MAX, 8'd0, 1'b0});
        send_word('{21'sd3, 8'd0, 1'b0});

        // random phases, every third one with no idling at all
        for (int p = 0; p < PHASES; p++) begin
            cs = random_setup();
            apply_setup(cs);
            no_gaps = (p % 3 == 2);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                w = random_word(cs);
                send_word(w);
            end
        end
        no_gaps = 1'b0;
        in_valid <= 1'b0;
        @(posedge i_clk);

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
sv/fim_pkg.sv
sv/fim_prep.sv
sv/fim_div.sv
sv/fim_map.sv
sv/frame_index_remap.sv
tb/fim_checker.sv
tb/frame_index_remap_tb.sv
